/* src/connection_tuple_lookup_table_defines.svh */
// Assertion macros shared by the connection tuple lookup table RTL.
// Included by any module that carries concurrent assertions; no other dependencies.
`ifndef CONNECTION_TUPLE_LOOKUP_TABLE_DEFINES_SVH
`define CONNECTION_TUPLE_LOOKUP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CTLT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctlt assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CTLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctlt assertion failed");

`endif

/* src/ctlt_pkg.sv */
// Package for the connection tuple lookup table: constants, operation codes,
// the tuple type and the token that travels down the cell chain. No dependencies.
package ctlt_pkg;

   localparam int ENTRIES_DEF = 16;
   // Slot numbers inside the chain are carried at the width of the largest table.
   localparam int SLOT_W      = 8;
   localparam int KIND_W      = 2;
   localparam int IDX_W       = 4;
   localparam int RSP_SLOT_W  = 4;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   typedef struct packed {
      logic [31:0] laddr;
      logic [15:0] lport;
      logic [31:0] raddr;
      logic [15:0] rport;
   } tuple_type;

   // One request in flight, plus what the cells passed so far have found.
   typedef struct packed {
      logic              active;
      logic [KIND_W-1:0] kind;
      tuple_type         query;
      logic [IDX_W-1:0]  slot_index;
      logic              ex_found;
      logic [SLOT_W-1:0] ex_slot;
      logic              wc_found;
      logic [SLOT_W-1:0] wc_slot;
      logic              ins_done;
      logic [SLOT_W-1:0] ins_slot;
   } token_type;

endpackage

/* src/ctlt_if.sv */
// Valid/ready channel interfaces for the request and response beats.
// Depends on nothing; payload widths follow the block's field widths.
interface ctlt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] local_addr;
   logic [15:0] local_port;
   logic [31:0] remote_addr;
   logic [15:0] remote_port;
   logic [3:0]  slot_index;

   modport source (output valid, kind, local_addr, local_port, remote_addr,
                   remote_port, slot_index, input ready);
   modport sink   (input valid, kind, local_addr, local_port, remote_addr,
                   remote_port, slot_index, output ready);
endinterface

interface ctlt_rsp_if;
   logic       valid;
   logic       ready;
   logic       hit;
   logic [3:0] slot;
   logic       exact;
   logic       full_res;

   modport source (output valid, hit, slot, exact, full_res, input ready);
   modport sink   (input valid, hit, slot, exact, full_res, output ready);
endinterface

/* src/connection_tuple_lookup_table.sv */
// Connection tuple lookup table: a chain of ENTRIES slot cells that a request token walks.
// A request passes the head register, each cell's token register and the output register;
// one request walks the chain at a time, and the chain holds while the output is stalled;
// the next request is taken once the previous one has left the chain for the output register.
// Reset (synchronous, active high) clears every valid mark at once; stored tuples are kept.
// Depends on ctlt_pkg, ctlt_if, ctlt_cell and connection_tuple_lookup_table_defines.svh.
`include "connection_tuple_lookup_table_defines.svh"

module connection_tuple_lookup_table #(
   parameter int ENTRIES = ctlt_pkg::ENTRIES_DEF
) (
   input logic        clock,
   input logic        reset,
   ctlt_req_if.sink   req_chan,
   ctlt_rsp_if.source rsp_chan
);

   // link[k] feeds cell k; link[ENTRIES] is the token leaving the last cell.
   ctlt_pkg::token_type link [ENTRIES+1];
   ctlt_pkg::token_type head_ff;
   ctlt_pkg::token_type last_tok;
   logic [ENTRIES:0]    act_vec;

   logic in_chain_ff;
   logic in_chain_in;
   logic req_take;
   logic advance;
   logic finish;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              rsp_hit_ff;
   logic                              rsp_hit_in;
   logic [ctlt_pkg::RSP_SLOT_W-1:0]   rsp_slot_ff;
   logic [ctlt_pkg::RSP_SLOT_W-1:0]   rsp_slot_in;
   logic                              rsp_exact_ff;
   logic                              rsp_exact_in;
   logic                              rsp_full_ff;
   logic                              rsp_full_in;

   // Only one request lives in the chain at a time, so the request side is open
   // whenever the chain is empty, even while a finished response beat still waits.
   // It stays closed while reset is high so that no beat is taken and then dropped.
   assign req_chan.ready = !in_chain_ff && !reset;
   assign req_take       = req_chan.valid && req_chan.ready;

   // The whole chain holds when the finished token cannot move into a busy output.
   assign last_tok = link[ENTRIES];
   assign advance  = !(last_tok.active && rsp_valid_ff && !rsp_chan.ready);
   assign finish   = last_tok.active && advance;

   assign link[0] = head_ff;

   // Head register: the accepted request, packed into a fresh token.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.active <= 1'b0;
      end else if (req_take) begin
         head_ff.active           <= 1'b1;
         head_ff.kind             <= req_chan.kind;
         head_ff.query.laddr      <= req_chan.local_addr;
         head_ff.query.lport      <= req_chan.local_port;
         head_ff.query.raddr      <= req_chan.remote_addr;
         head_ff.query.rport      <= req_chan.remote_port;
         head_ff.slot_index       <= req_chan.slot_index;
         head_ff.ex_found         <= 1'b0;
         head_ff.ex_slot          <= '0;
         head_ff.wc_found         <= 1'b0;
         head_ff.wc_slot          <= '0;
         head_ff.ins_done         <= 1'b0;
         head_ff.ins_slot         <= '0;
      end else if (advance) begin
         head_ff.active <= 1'b0;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         ctlt_cell #(
            .CELL_ID(gi)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .advance(advance),
            .tok_in (link[gi]),
            .tok_out(link[gi+1])
         );
      end
      for (gi = 0; gi <= ENTRIES; gi++) begin : g_act
         assign act_vec[gi] = link[gi].active;
      end
   endgenerate

   // Result formation from the token that has passed every slot. An exact hit
   // anywhere beats a wildcard hit in a lower slot; within each, the lowest slot wins.
   always_comb begin
      rsp_hit_in   = 1'b0;
      rsp_slot_in  = '0;
      rsp_exact_in = 1'b0;
      rsp_full_in  = 1'b0;
      case (last_tok.kind)
         ctlt_pkg::KIND_INSERT: begin
            rsp_hit_in  = last_tok.ins_done;
            rsp_full_in = !last_tok.ins_done;
            if (last_tok.ins_done) begin
               rsp_slot_in = (ctlt_pkg::RSP_SLOT_W)'(last_tok.ins_slot);
            end
         end
         ctlt_pkg::KIND_REMOVE: begin
            rsp_slot_in = (ctlt_pkg::RSP_SLOT_W)'(last_tok.slot_index);
         end
         ctlt_pkg::KIND_LOOKUP: begin
            if (last_tok.ex_found) begin
               rsp_hit_in   = 1'b1;
               rsp_exact_in = 1'b1;
               rsp_slot_in  = (ctlt_pkg::RSP_SLOT_W)'(last_tok.ex_slot);
            end else if (last_tok.wc_found) begin
               rsp_hit_in  = 1'b1;
               rsp_slot_in = (ctlt_pkg::RSP_SLOT_W)'(last_tok.wc_slot);
            end
         end
         default: begin
            rsp_hit_in = 1'b0;
         end
      endcase

      in_chain_in = in_chain_ff;
      if (req_take) begin
         in_chain_in = 1'b1;
      end else if (finish) begin
         in_chain_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_chain_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_chain_ff  <= in_chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_hit_ff   <= rsp_hit_in;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_exact_ff <= rsp_exact_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.slot     = rsp_slot_ff;
   assign rsp_chan.exact    = rsp_exact_ff;
   assign rsp_chan.full_res = rsp_full_ff;

   // At most one token is alive anywhere along the chain.
   `CTLT_ASSERT_NOW(a_single_token, clock, reset, 1'b1, $onehot0(act_vec))
   // A token is alive exactly while the chain is marked busy.
   `CTLT_ASSERT_NOW(a_busy_tracks_token, clock, reset, 1'b1, in_chain_ff == (|act_vec))
   // A taken request shows up in the head register on the next edge.
   `CTLT_ASSERT_NEXT(a_take_loads_head, clock, reset, req_take, head_ff.active)
   // An exact match is always a hit, and a full table is never a hit.
   `CTLT_ASSERT_NOW(a_rsp_consistent, clock, reset, rsp_valid_ff,
                    (!rsp_exact_ff || rsp_hit_ff) && !(rsp_hit_ff && rsp_full_ff))

endmodule

/* src/ctlt_cell.sv */
// One table slot: valid mark, stored tuple and a token register toward the next cell.
// Depends on ctlt_pkg.
module ctlt_cell #(
   parameter int CELL_ID = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ctlt_pkg::token_type tok_in,
   output ctlt_pkg::token_type tok_out
);

   localparam logic [ctlt_pkg::SLOT_W-1:0] MY_SLOT = (ctlt_pkg::SLOT_W)'(CELL_ID);

   logic                valid_ff;
   logic                valid_in;
   ctlt_pkg::tuple_type tuple_ff;
   ctlt_pkg::token_type token_ff;
   ctlt_pkg::token_type token_in;
   logic                exact_match;
   logic                wild_match;
   logic                do_insert;
   logic                do_remove;

   always_comb begin
      exact_match = valid_ff && (tuple_ff == tok_in.query);
      wild_match  = valid_ff && (tuple_ff.lport == tok_in.query.lport) &&
                    ((tuple_ff.laddr == 32'd0) || (tuple_ff.laddr == tok_in.query.laddr));
      do_insert   = tok_in.active && (tok_in.kind == ctlt_pkg::KIND_INSERT) &&
                    !tok_in.ins_done && !valid_ff;
      do_remove   = tok_in.active && (tok_in.kind == ctlt_pkg::KIND_REMOVE) &&
                    ((ctlt_pkg::SLOT_W)'(tok_in.slot_index) == MY_SLOT);

      token_in = tok_in;
      if (tok_in.kind == ctlt_pkg::KIND_LOOKUP) begin
         if (exact_match && !tok_in.ex_found) begin
            token_in.ex_found = 1'b1;
            token_in.ex_slot  = MY_SLOT;
         end
         if (wild_match && !tok_in.wc_found) begin
            token_in.wc_found = 1'b1;
            token_in.wc_slot  = MY_SLOT;
         end
      end
      if (do_insert) begin
         token_in.ins_done = 1'b1;
         token_in.ins_slot = MY_SLOT;
      end

      valid_in = valid_ff;
      if (do_insert) begin
         valid_in = 1'b1;
      end else if (do_remove) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         token_ff.active <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
         token_ff <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && do_insert) begin
         tuple_ff <= tok_in.query;
      end
   end

   assign tok_out = token_ff;

endmodule

/* verif/connection_tuple_lookup_table_tb.sv */
// Testbench for the connection tuple lookup table: directed and random insert, remove and lookup beats.
// A scoreboard class predicts every response beat and checks it against the block's output.
// Depends on ctlt_pkg, the ctlt_req_if and ctlt_rsp_if interfaces and connection_tuple_lookup_table.
`timescale 1ns / 1ps

module connection_tuple_lookup_table_tb;
   import ctlt_pkg::*;

   localparam int ENTRIES      = ENTRIES_DEF;
   localparam int RANDOM_BEATS = 830;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int POOL_SIZE    = 8;

   // The fourth operation code is not used by the block; it must answer with an all-zero beat.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // One response beat as the block should present it.
   typedef struct packed {
      logic                  hit;
      logic [RSP_SLOT_W-1:0] slot;
      logic                  exact;
      logic                  full_res;
   } reply_type;

   // The scoreboard keeps its own copy of the table. Each accepted request beat updates that
   // copy and queues the response it implies; each response beat is checked against the
   // oldest queued one.
   class conn_table_scoreboard;
      bit          slot_live[ENTRIES];
      tuple_type   slot_tuple[ENTRIES];
      reply_type   expected_replies[$];
      int          error_count;

      function new();
         for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i]  = 1'b0;
            slot_tuple[i] = '0;
         end
         error_count = 0;
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         error_count++;
      endtask

      function int pending();
         return expected_replies.size();
      endfunction

      // Picks one occupied slot at random, or returns -1 when the table is empty.
      function int random_live_slot();
         int live[$];
         for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i])
               live.push_back(i);
         if (live.size() == 0)
            return -1;
         return live[$urandom_range(0, live.size() - 1)];
      endfunction

      // Applies one request to the table copy and returns the response it should produce.
      function reply_type predict_table_reply(input logic [KIND_W-1:0] kind,
                                              input tuple_type q,
                                              input logic [IDX_W-1:0] idx);
         reply_type r;
         bit        found;
         r     = '0;
         found = 1'b0;
         case (kind)
            KIND_INSERT: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!found && !slot_live[i]) begin
                     found         = 1'b1;
                     slot_live[i]  = 1'b1;
                     slot_tuple[i] = q;
                     r.hit         = 1'b1;
                     r.slot        = i[RSP_SLOT_W-1:0];
                  end
               end
               if (!found)
                  r.full_res = 1'b1;
            end
            KIND_REMOVE: begin
               if (int'(idx) < ENTRIES)
                  slot_live[idx] = 1'b0;
               r.slot = idx;
            end
            KIND_LOOKUP: begin
               // Exact pass first, lowest slot wins.
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!found && slot_live[i] && slot_tuple[i] == q) begin
                     found   = 1'b1;
                     r.hit   = 1'b1;
                     r.slot  = i[RSP_SLOT_W-1:0];
                     r.exact = 1'b1;
                  end
               end
               // Listener pass: same local port, stored address is any or the query's.
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!found && slot_live[i] && slot_tuple[i].lport == q.lport &&
                      (slot_tuple[i].laddr == '0 || slot_tuple[i].laddr == q.laddr)) begin
                     found  = 1'b1;
                     r.hit  = 1'b1;
                     r.slot = i[RSP_SLOT_W-1:0];
                  end
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(input logic [KIND_W-1:0] kind, input tuple_type q,
                                 input logic [IDX_W-1:0] idx);
         expected_replies.push_back(predict_table_reply(kind, q, idx));
      endfunction

      task check_response(input reply_type got);
         reply_type want;
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("response beat with no request waiting: %p", got));
         end else begin
            want = expected_replies.pop_front();
            if (got.hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
            if (got.slot !== want.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
            if (got.exact !== want.exact)
               report_mismatch($sformatf("exact %b, expected %b", got.exact, want.exact));
            if (got.full_res !== want.full_res)
               report_mismatch($sformatf("full_res %b, expected %b",
                                         got.full_res, want.full_res));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   ctlt_req_if req_bus ();
   ctlt_rsp_if rsp_bus ();

   connection_tuple_lookup_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   conn_table_scoreboard sb;

   // While a quiet spell is on, neither side starts new gaps or stalls.
   bit quiet_spell;
   // Alternating phases lean toward filling the table or toward draining it.
   bit fill_heavy;
   int cycle_count;
   int stall_left;

   // A small pool of connections, so that lookups find stored entries often. The ports are
   // shared among pool members, which makes listener matches and lowest-slot priority common.
   tuple_type   conn_pool[POOL_SIZE];
   logic [15:0] pool_ports[3];

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Global watchdog: a run that hangs ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Every accepted response beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response({rsp_bus.hit, rsp_bus.slot, rsp_bus.exact, rsp_bus.full_res});
   end

   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(15, 40);
   endfunction

   // The response side stalls now and then, for a length drawn from pick_idle_len.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left      <= stall_left - 1;
         rsp_bus.ready   <= 1'b0;
      end else if (!quiet_spell && $urandom_range(0, 99) < 20) begin
         stall_left      <= pick_idle_len() - 1;
         rsp_bus.ready   <= 1'b0;
      end else begin
         rsp_bus.ready   <= 1'b1;
      end
   end

   function automatic tuple_type make_tuple(input logic [31:0] la, input logic [15:0] lp,
                                            input logic [31:0] ra, input logic [15:0] rp);
      tuple_type t;
      t.laddr = la;
      t.lport = lp;
      t.raddr = ra;
      t.rport = rp;
      return t;
   endfunction

   function automatic tuple_type random_tuple();
      return make_tuple($urandom, 16'($urandom), $urandom, 16'($urandom));
   endfunction

   // Drives one request beat, after a random number of idle cycles, and waits until it is
   // taken. The scoreboard learns of the beat at the edge where it is accepted.
   task automatic send_request(input logic [KIND_W-1:0] kind, input tuple_type t,
                               input logic [IDX_W-1:0] idx);
      int gap;
      int r;
      gap = 0;
      if (!quiet_spell) begin
         r = $urandom_range(0, 99);
         if (r >= 60)
            gap = pick_idle_len();
      end
      if (gap > 0) begin
         @(negedge clock) req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.local_addr  <= t.laddr;
      req_bus.local_port  <= t.lport;
      req_bus.remote_addr <= t.raddr;
      req_bus.remote_port <= t.rport;
      req_bus.slot_index  <= idx;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sb.note_request(kind, t, idx);
   endtask

   // Directed opening: field extremes, both lookup passes, a miss, the unused code,
   // filling the table to the point of refusing an insert, and the highest remove index.
   task automatic run_directed();
      tuple_type ones;
      tuple_type listener;
      ones     = make_tuple(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      listener = make_tuple(32'h0, 16'h0050, 32'h0A00_0001, 16'hC000);
      send_request(KIND_INSERT, ones, 4'h0);
      send_request(KIND_INSERT, listener, 4'h0);
      // Exact hit on slot 0.
      send_request(KIND_LOOKUP, ones, 4'h0);
      // Listener hit through the any address stored in slot 1.
      send_request(KIND_LOOKUP, make_tuple(32'hC0A8_0001, 16'h0050, 32'h0A00_0002, 16'h1234),
                   4'h0);
      // Listener hit on slot 0 through an equal local address with a different remote end.
      send_request(KIND_LOOKUP, make_tuple(32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0), 4'h0);
      // No port matches at all.
      send_request(KIND_LOOKUP, make_tuple(32'h0, 16'h1F90, 32'h0, 16'h0), 4'h0);
      send_request(KIND_UNUSED, make_tuple(32'h0, 16'h0, 32'h0, 16'h0), 4'h0);
      send_request(KIND_REMOVE, ones, 4'h0);
      // The removed entry must no longer be found.
      send_request(KIND_LOOKUP, ones, 4'h0);
      // Refill slot 0 and then slots 2 to 15; the table is then full.
      for (int i = 0; i < ENTRIES - 1; i++)
         send_request(KIND_INSERT,
                      make_tuple(32'h0A00_0000 | i, 16'(1000 + i),
                                 32'hC0A8_0100 | i, 16'(40000 + i)),
                      4'h0);
      send_request(KIND_INSERT, make_tuple(32'h0, 16'h0, 32'h0, 16'h0), 4'h0);
      send_request(KIND_REMOVE, make_tuple(32'h0, 16'h0, 32'h0, 16'h0), 4'hF);
   endtask

   // Builds one random request. Most are well formed: inserts and lookups of pool
   // connections and removes of occupied slots; the rest are fully random beats.
   task automatic make_random_request(output logic [KIND_W-1:0] kind, output tuple_type t,
                                      output logic [IDX_W-1:0] idx);
      int r;
      int ins_weight;
      int rem_weight;
      int live;
      ins_weight = fill_heavy ? 42 : 22;
      rem_weight = fill_heavy ? 18 : 38;
      r   = $urandom_range(0, 99);
      t   = conn_pool[$urandom_range(0, POOL_SIZE - 1)];
      idx = IDX_W'($urandom_range(0, 15));
      if (r < ins_weight) begin
         kind = KIND_INSERT;
         if ($urandom_range(0, 4) == 0)
            t = random_tuple();
      end else if (r < ins_weight + rem_weight) begin
         kind = KIND_REMOVE;
         live = sb.random_live_slot();
         if (live >= 0 && $urandom_range(0, 3) != 0)
            idx = live[IDX_W-1:0];
         t = random_tuple();
      end else if (r < 96) begin
         kind = KIND_LOOKUP;
         r    = $urandom_range(0, 99);
         if (r < 40) begin
            // Exact copy of a pool connection.
         end else if (r < 75) begin
            // Same local port, new remote end, sometimes a new local address.
            t.raddr = $urandom;
            t.rport = 16'($urandom);
            if ($urandom_range(0, 1) == 0)
               t.laddr = $urandom;
         end else begin
            t = random_tuple();
         end
      end else begin
         kind = KIND_UNUSED;
         t    = random_tuple();
      end
   endtask

   initial begin
      logic [KIND_W-1:0] kind;
      tuple_type         t;
      logic [IDX_W-1:0]  idx;

      sb          = new();
      quiet_spell = 1'b0;
      fill_heavy  = 1'b1;
      cycle_count = 0;
      stall_left  = 0;
      reset       = 1'b1;

      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_INSERT;
      req_bus.local_addr  = '0;
      req_bus.local_port  = '0;
      req_bus.remote_addr = '0;
      req_bus.remote_port = '0;
      req_bus.slot_index  = '0;
      rsp_bus.ready       = 1'b0;

      for (int i = 0; i < 3; i++)
         pool_ports[i] = 16'($urandom);
      // A quarter of the pool listens on any local address.
      for (int i = 0; i < POOL_SIZE; i++) begin
         conn_pool[i]       = random_tuple();
         conn_pool[i].lport = pool_ports[$urandom_range(0, 2)];
         if (i % 4 == 0)
            conn_pool[i].laddr = '0;
      end

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      run_directed();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         quiet_spell = ((n / 50) % 4) == 3;
         fill_heavy  = ((n / 150) % 2) == 0;
         make_random_request(kind, t, idx);
         send_request(kind, t, idx);
      end
      @(negedge clock) req_bus.valid <= 1'b0;
      quiet_spell = 1'b0;

      // Drain: wait for every predicted beat, then a little longer for stray beats.
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);

      if (sb.error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
